// ----- rtl/cbpw_pkg.sv -----
// package for the corner blit pixel writer
// register indexes, field widths and the channel packing function; no dependencies
`default_nettype none
package cbpw_pkg;

   localparam int COUNTER_BITS = 12;
   localparam int ADDRESS_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 36;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 72;

   localparam logic [12:0] SCREEN_WIDTH_RESET = 13'd1920;
   localparam logic [15:0] LINE_PITCH_RESET = 16'd7680;
   localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd64;
   localparam logic [11:0] IMAGE_HEIGHT_RESET = 12'd64;
   localparam logic [11:0] EDGE_MARGIN_RESET = 12'd20;
   localparam logic [2:0] PIXEL_BYTES_RESET = 3'd4;
   localparam logic [35:0] PIXEL_LAYOUT_RESET = 36'd2167048;

   localparam logic [7:0] ALPHA_FULL = 8'hff;
   localparam logic [3:0] CHANNEL_MAX_LEN = 4'd8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH = 3'd0,
      CSR_LINE_PITCH = 3'd1,
      CSR_IMAGE_WIDTH = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_EDGE_MARGIN = 3'd4,
      CSR_PIXEL_BYTES = 3'd5,
      CSR_PIXEL_LAYOUT = 3'd6
   } csr_index_type;

   // top bits of the component, placed at the channel offset
   function automatic logic [31:0] place_channel(input logic [7:0] value,
                                                 input logic [8:0] field);
      logic [3:0] len;
      logic [7:0] shifted;
      logic [38:0] wide;
      len = (field[3:0] > CHANNEL_MAX_LEN) ? CHANNEL_MAX_LEN : field[3:0];
      shifted = value >> (CHANNEL_MAX_LEN - len);
      wide = {31'd0, shifted} << field[8:4];
      if (len == 4'd0) begin
         wide = '0;
      end
      return wide[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/corner_blit_pixel_writer.sv -----
// corner blit pixel writer: places a raster-order RGB image in the top-right
// corner of a framebuffer with at most one packed write per pixel; uses cbpw_pkg
`default_nettype none
// Accepts one pixel per clock while the output is not stalled and returns at
// most one write per pixel. An accepted pixel is held in the input register;
// its address and packed word then move into the result register, from which
// the write is taken. A stalled write keeps the input register full and then
// blocks the input. Pixels of an image that does not fit the screen width, or
// with a pixel size other than 2, 3 or 4 bytes, give no write but still advance
// the column and row counters. The user must write configuration only while no
// transaction is in flight; the block itself does not enforce this.
module corner_blit_pixel_writer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [cbpw_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // write_address [31:0], write_data [63:32], byte_count [66:64], zero pad
   output logic [cbpw_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // image_end
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [cbpw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [cbpw_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cbpw_pkg::*;

   logic [12:0] screen_width_ff;
   logic [15:0] line_pitch_ff;
   logic [11:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [11:0] edge_margin_ff;
   logic [2:0]  pixel_bytes_ff;
   logic [35:0] pixel_layout_ff;

   logic [COUNTER_BITS-1:0] column_ff, column_in;
   logic [COUNTER_BITS-1:0] row_ff, row_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic [23:0]             s1_pixel_ff;
   logic [COUNTER_BITS-1:0] s1_column_ff;
   logic [COUNTER_BITS-1:0] s1_row_ff;
   logic                    s1_last_ff, s1_last_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic [ADDRESS_BITS-1:0] s2_addr_ff, s2_addr_in;
   logic [31:0]             s2_data_ff, s2_data_in;
   logic [2:0]              s2_count_ff;
   logic                    s2_last_ff;

   logic        accept, load2;
   logic [11:0] width_eff, height_eff;
   logic        row_end, col_end_row;
   logic        fits, size_ok, emit;
   logic [12:0] x0;
   logic [13:0] col_sum;
   logic [12:0] row_sum;
   logic [16:0] col_prod;
   logic [28:0] row_prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RESET;
         line_pitch_ff <= LINE_PITCH_RESET;
         image_width_ff <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         edge_margin_ff <= EDGE_MARGIN_RESET;
         pixel_bytes_ff <= PIXEL_BYTES_RESET;
         pixel_layout_ff <= PIXEL_LAYOUT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:    screen_width_ff <= csr_wdata[12:0];
            CSR_LINE_PITCH:      line_pitch_ff <= csr_wdata[15:0];
            CSR_IMAGE_WIDTH:     image_width_ff <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT:    image_height_ff <= csr_wdata[11:0];
            CSR_EDGE_MARGIN:     edge_margin_ff <= csr_wdata[11:0];
            CSR_PIXEL_BYTES:     pixel_bytes_ff <= csr_wdata[2:0];
            CSR_PIXEL_LAYOUT:    pixel_layout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      load2 = s1_valid_ff && (!s2_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || load2;
      accept = req_tvalid && req_tready;
   end

   // counters and write qualification
   always_comb begin
      width_eff = (image_width_ff == 12'd0) ? 12'd1 : image_width_ff;
      height_eff = (image_height_ff == 12'd0) ? 12'd1 : image_height_ff;
      row_end = ({1'b0, column_ff} + 13'd1) >= {1'b0, width_eff};
      col_end_row = ({1'b0, row_ff} + 13'd1) >= {1'b0, height_eff};
      s1_last_in = row_end && col_end_row;
      fits = {1'b0, screen_width_ff} >= ({2'b0, image_width_ff} + {2'b0, edge_margin_ff});
      size_ok = (pixel_bytes_ff >= 3'd2) && (pixel_bytes_ff <= 3'd4);
      emit = fits && size_ok;

      column_in = column_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            column_in = '0;
            row_in = col_end_row ? '0 : row_ff + 12'd1;
         end else begin
            column_in = column_ff + 12'd1;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = emit;
      end else if (load2) begin
         s1_valid_in = 1'b0;
      end
   end

   // address and packing
   always_comb begin
      x0 = screen_width_ff - {1'b0, image_width_ff} - {1'b0, edge_margin_ff};
      col_sum = {1'b0, x0} + {2'b0, s1_column_ff};
      row_sum = {1'b0, edge_margin_ff} + {1'b0, s1_row_ff};
      col_prod = {3'b0, col_sum} * {14'b0, pixel_bytes_ff};
      row_prod = {16'b0, row_sum} * {13'b0, line_pitch_ff};
      s2_addr_in = {3'b0, row_prod} + {15'b0, col_prod};
      s2_data_in = place_channel(s1_pixel_ff[7:0], pixel_layout_ff[8:0])
                 | place_channel(s1_pixel_ff[15:8], pixel_layout_ff[17:9])
                 | place_channel(s1_pixel_ff[23:16], pixel_layout_ff[26:18])
                 | place_channel(ALPHA_FULL, pixel_layout_ff[35:27]);
      s2_valid_in = s2_valid_ff;
      if (load2) begin
         s2_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_tdata;
         s1_column_ff <= column_ff;
         s1_row_ff <= row_ff;
         s1_last_ff <= s1_last_in;
      end
      if (load2) begin
         s2_addr_ff <= s2_addr_in;
         s2_data_ff <= s2_data_in;
         s2_count_ff <= pixel_bytes_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata = {5'b0, s2_count_ff, s2_data_ff, s2_addr_ff};
   assign rsp_tlast = s2_last_ff;

`ifndef NO_ASSERTIONS
   // only supported pixel sizes reach the output
   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (s2_count_ff == 3'd2 || s2_count_ff == 3'd3 || s2_count_ff == 3'd4))
      else $error("unsupported byte count on output");

   // a suppressed pixel leaves the input register empty
   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      (accept && !emit) |=> !s1_valid_ff)
      else $error("suppressed pixel entered pipeline");

   // a stalled write holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled write changed");

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire
